### design/cs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cs_pkg
// Shared constants and helpers for the comment stripper: register indexes
// and marker byte extraction.
// ----------------------------------------------------------------------------
package cs_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned LEN_W       = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_MARKER      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_MARKER_LEN  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_OPENER     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_OPENER_LEN = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_CLOSER     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_CLOSER_LEN = 3'd5;

   localparam logic [31:0]      LINE_MARKER_RST      = 32'h0000_2F2F;
   localparam logic [LEN_W-1:0] LINE_MARKER_LEN_RST  = 3'd2;
   localparam logic [31:0]      BLOCK_OPENER_RST     = 32'h0000_2A2F;
   localparam logic [LEN_W-1:0] BLOCK_OPENER_LEN_RST = 3'd2;
   localparam logic [31:0]      BLOCK_CLOSER_RST     = 32'h0000_2F2A;
   localparam logic [LEN_W-1:0] BLOCK_CLOSER_LEN_RST = 3'd2;

   localparam logic [7:0] NL_CHAR = 8'h0A;

   // Byte k of a marker word; bytes past the fourth read as zero.
   function automatic logic [7:0] mark_byte(logic [31:0] m, int unsigned k);
      logic [31:0] sh;
      sh = m >> (8 * k);
      return (k < 4) ? sh[7:0] : 8'h00;
   endfunction

endpackage

### design/cs_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cs_match
// Prefix compare unit: counts how many leading window bytes agree with a
// marker word.
// ----------------------------------------------------------------------------
module cs_match #(
   parameter int MAX_DELIM = 4
) (
   input  logic [7:0]                       win [MAX_DELIM],
   input  logic [31:0]                      marker,
   output logic [$clog2(MAX_DELIM+1)-1:0]   mlen
);

   localparam int CW = $clog2(MAX_DELIM + 1);

   always_comb begin : prefix_count
      logic miss;
      miss = 1'b0;
      mlen = '0;
      for (int j = 0; j < MAX_DELIM; j++) begin
         if (!miss && (win[j] == cs_pkg::mark_byte(marker, j))) begin
            mlen = CW'(j + 1);
         end else begin
            miss = 1'b1;
         end
      end
   end

endmodule

### design/cs_closer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cs_closer
// Block closer tracker: given the current partial closer match and one new
// byte, find the longest tail that still begins the closer.
// ----------------------------------------------------------------------------
module cs_closer #(
   parameter int MAX_DELIM = 4
) (
   input  logic [$clog2(MAX_DELIM+1)-1:0] progress,
   input  logic [7:0]                     cin,
   input  logic [31:0]                    closer,
   input  logic [$clog2(MAX_DELIM+1)-1:0] cl,
   output logic [$clog2(MAX_DELIM+1)-1:0] match_len
);

   localparam int CW = $clog2(MAX_DELIM + 1);

   always_comb begin : closer_search
      int unsigned p;
      int unsigned idx;
      logic        ok;
      logic [7:0]  sb;
      // restart when a register change left progress out of range
      p = (progress >= cl) ? 0 : int'(progress);
      match_len = '0;
      for (int unsigned kk = 1; kk <= MAX_DELIM; kk++) begin
         ok = (kk <= p + 1) && (kk <= int'(cl));
         for (int unsigned i = 0; i < MAX_DELIM; i++) begin
            if (i < kk) begin
               idx = p + 1 - kk + i;
               sb  = (idx == p) ? cin : cs_pkg::mark_byte(closer, idx);
               if (sb != cs_pkg::mark_byte(closer, i)) begin
                  ok = 1'b0;
               end
            end
         end
         if (ok) begin
            match_len = CW'(kk);
         end
      end
   end

endmodule

### design/comment_stripper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// comment_stripper
// Removes line comments and block comments from a byte stream, with
// programmable markers.
// ----------------------------------------------------------------------------
// The block takes one text byte per req transfer and returns the kept bytes
// on rsp, zero to MAX_DELIM of them per input byte; rsp_tlast marks the last
// byte caused by one input and rsp_tuser the last byte of the whole text.
// An input byte that yields no output produces no rsp transfer at all.
// Each input passes through a load step, then scan steps through the q
// queued bytes (the waiting bytes plus the new one) and a step that closes
// the scan, then on req_tlast flush steps that emit the waiting bytes and
// a step that clears the text state, and finally the drain, one result per
// cycle while rsp_tready is high, or a return to idle when the input causes
// no result. A failed marker prefix is rescanned: each emitted byte rescans
// the bytes behind it. The scan examines one byte per step through the
// shared compare logic: the line and opener prefix matchers and the closer
// tracker.
// req_tready is high only between inputs; the output register lets the next
// input load while the last result still waits for rsp_tready.
// Registers are written through csr_we / csr_index / csr_wdata and should be
// changed only while the block is idle.
// ----------------------------------------------------------------------------
module comment_stripper #(
   parameter int MAX_DELIM = 4
) (
   input  logic        clock,
   input  logic        reset,
   // configuration write port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   // input text
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] in_byte
   input  logic        req_tlast,    // end_of_input
   // stripped text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] out_byte
   output logic        rsp_tlast,    // run_last
   output logic        rsp_tuser     // [0] text_done
);

   localparam int CW = $clog2(MAX_DELIM + 1);
   localparam int IW = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FLUSH,
      S_DRAIN
   } state_type;

   typedef enum logic [1:0] {
      MODE_TEXT,
      MODE_LINE,
      MODE_BLOCK
   } mode_type;

   // configuration registers
   logic [31:0]              line_marker_ff;
   logic [cs_pkg::LEN_W-1:0] line_len_ff;
   logic [31:0]              opener_ff;
   logic [cs_pkg::LEN_W-1:0] opener_len_ff;
   logic [31:0]              closer_ff;
   logic [cs_pkg::LEN_W-1:0] closer_len_ff;

   // sequencer state
   state_type       state_ff, state_in;
   mode_type        mode_ff, mode_in;
   logic [7:0]      q_ff [MAX_DELIM];
   logic [7:0]      q_in [MAX_DELIM];
   logic [CW-1:0]   qlen_ff, qlen_in;
   logic [CW-1:0]   pos_ff, pos_in;
   logic [CW-1:0]   pc_ff, pc_in;
   logic [CW-1:0]   pstart_ff, pstart_in;
   logic [CW-1:0]   cp_ff, cp_in;
   logic [CW-1:0]   s_ff, s_in;
   logic            last_ff, last_in;
   logic [7:0]      res_ff [MAX_DELIM];
   logic [7:0]      res_in [MAX_DELIM];
   logic [CW-1:0]   rcnt_ff, rcnt_in;
   logic [CW-1:0]   rd_ff, rd_in;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_data_ff, rsp_data_in;
   logic            rsp_last_ff, rsp_last_in;
   logic            rsp_done_ff, rsp_done_in;

   // shared compare unit
   logic [7:0]      win [MAX_DELIM];
   logic [CW-1:0]   line_mlen;
   logic [CW-1:0]   open_mlen;
   logic [CW-1:0]   closer_len;
   logic [CW-1:0]   ll, bl, cl;
   logic [7:0]      scan_byte;

   // ------------------------------------------------------------------
   // Configuration writes
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         line_marker_ff <= cs_pkg::LINE_MARKER_RST;
         line_len_ff    <= cs_pkg::LINE_MARKER_LEN_RST;
         opener_ff      <= cs_pkg::BLOCK_OPENER_RST;
         opener_len_ff  <= cs_pkg::BLOCK_OPENER_LEN_RST;
         closer_ff      <= cs_pkg::BLOCK_CLOSER_RST;
         closer_len_ff  <= cs_pkg::BLOCK_CLOSER_LEN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            cs_pkg::CSR_LINE_MARKER:      line_marker_ff <= csr_wdata;
            cs_pkg::CSR_LINE_MARKER_LEN:  line_len_ff    <= csr_wdata[cs_pkg::LEN_W-1:0];
            cs_pkg::CSR_BLOCK_OPENER:     opener_ff      <= csr_wdata;
            cs_pkg::CSR_BLOCK_OPENER_LEN: opener_len_ff  <= csr_wdata[cs_pkg::LEN_W-1:0];
            cs_pkg::CSR_BLOCK_CLOSER:     closer_ff      <= csr_wdata;
            cs_pkg::CSR_BLOCK_CLOSER_LEN: closer_len_ff  <= csr_wdata[cs_pkg::LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Clamp marker lengths into 1..MAX_DELIM.
   function automatic logic [CW-1:0] eff_len(logic [cs_pkg::LEN_W-1:0] l);
      if (l == '0) begin
         return CW'(1);
      end else if (int'(l) > MAX_DELIM) begin
         return CW'(MAX_DELIM);
      end
      return CW'(l);
   endfunction

   assign ll = eff_len(line_len_ff);
   assign bl = eff_len(opener_len_ff);
   assign cl = eff_len(closer_len_ff);

   // ------------------------------------------------------------------
   // Window onto the byte queue: waiting bytes while scanning, the
   // remaining tail while flushing at end of text.
   // ------------------------------------------------------------------
   always_comb begin : window_select
      int unsigned base;
      logic [IW-1:0] idx;
      if (state_ff == S_FLUSH) begin
         base = int'(qlen_ff) - int'(pc_ff) + int'(s_ff);
      end else begin
         base = int'(pos_ff) - int'(pc_ff);
      end
      for (int unsigned j = 0; j < MAX_DELIM; j++) begin
         idx = IW'(base + j);
         win[j] = (base + j < MAX_DELIM) ? q_ff[idx] : 8'h00;
      end
   end

   assign scan_byte = q_ff[pos_ff[IW-1:0]];

   cs_match #(.MAX_DELIM(MAX_DELIM)) u_line_match (
      .win    (win),
      .marker (line_marker_ff),
      .mlen   (line_mlen)
   );

   cs_match #(.MAX_DELIM(MAX_DELIM)) u_open_match (
      .win    (win),
      .marker (opener_ff),
      .mlen   (open_mlen)
   );

   cs_closer #(.MAX_DELIM(MAX_DELIM)) u_closer (
      .progress  (cp_ff),
      .cin       (scan_byte),
      .closer    (closer_ff),
      .cl        (cl),
      .match_len (closer_len)
   );

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin : sequencer
      logic [CW-1:0] n;
      logic [CW-1:0] base;
      logic [CW-1:0] r;
      logic          brk;
      logic          slot_free;
      logic          fin;
      logic [IW-1:0] src;

      state_in     = state_ff;
      mode_in      = mode_ff;
      qlen_in      = qlen_ff;
      pos_in       = pos_ff;
      pc_in        = pc_ff;
      pstart_in    = pstart_ff;
      cp_in        = cp_ff;
      s_in         = s_ff;
      last_in      = last_ff;
      rcnt_in      = rcnt_ff;
      rd_in        = rd_ff;
      for (int i = 0; i < MAX_DELIM; i++) begin
         q_in[i]   = q_ff[i];
         res_in[i] = res_ff[i];
      end

      // drop the held result once it is taken
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;

      n         = pc_ff + CW'(1);
      base      = pos_ff - pc_ff;
      r         = pc_ff - s_ff;
      brk       = 1'b0;
      slot_free = !rsp_valid_ff || rsp_tready;
      fin       = 1'b0;
      src       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               // move waiting bytes to the front, append the new byte
               for (int unsigned i = 0; i < MAX_DELIM; i++) begin
                  src = IW'(int'(pstart_ff) + i);
                  if (i < pc_ff) begin
                     q_in[i] = q_ff[src];
                  end else if (i == pc_ff) begin
                     q_in[i] = req_tdata;
                  end
               end
               qlen_in  = pc_ff + CW'(1);
               pos_in   = '0;
               pc_in    = '0;
               rcnt_in  = '0;
               last_in  = req_tlast;
               state_in = S_SCAN;
            end
         end

         S_SCAN: begin
            if (pos_ff == qlen_ff) begin
               s_in  = '0;
               rd_in = '0;
               if (last_ff) begin
                  state_in = S_FLUSH;
               end else begin
                  pstart_in = qlen_ff - pc_ff;
                  state_in  = S_DRAIN;
               end
            end else if (mode_ff == MODE_LINE) begin
               if (scan_byte == cs_pkg::NL_CHAR) begin
                  mode_in = MODE_TEXT;
               end
               pos_in = pos_ff + CW'(1);
            end else if (mode_ff == MODE_BLOCK) begin
               if (closer_len >= cl) begin
                  mode_in = MODE_TEXT;
                  cp_in   = '0;
               end else begin
                  cp_in   = closer_len;
               end
               pos_in = pos_ff + CW'(1);
            end else begin
               if (n <= ll && line_mlen >= n) begin
                  // line marker wins while it can still complete
                  if (n == ll) begin
                     mode_in = MODE_LINE;
                     pc_in   = '0;
                  end else begin
                     pc_in   = n;
                  end
                  pos_in = pos_ff + CW'(1);
               end else if (n >= bl && open_mlen >= bl) begin
                  // open the comment; bytes after the opener are content
                  mode_in = MODE_BLOCK;
                  cp_in   = '0;
                  pc_in   = '0;
                  pos_in  = base + bl;
               end else if (n <= bl && open_mlen >= n) begin
                  pc_in  = n;
                  pos_in = pos_ff + CW'(1);
               end else begin
                  // emit the oldest waiting byte, rescan the rest
                  res_in[rcnt_ff[IW-1:0]] = win[0];
                  rcnt_in = rcnt_ff + CW'(1);
                  pc_in   = '0;
                  pos_in  = base + CW'(1);
               end
            end
         end

         S_FLUSH: begin
            brk = (r >= ll && line_mlen >= ll) || (r >= bl && open_mlen >= bl);
            if (mode_ff != MODE_TEXT || s_ff >= pc_ff || brk) begin
               // end of text: drop what is left and return to reset state
               mode_in  = MODE_TEXT;
               pc_in    = '0;
               cp_in    = '0;
               state_in = S_DRAIN;
            end else begin
               res_in[rcnt_ff[IW-1:0]] = win[0];
               rcnt_in = rcnt_ff + CW'(1);
               s_in    = s_ff + CW'(1);
            end
         end

         S_DRAIN: begin
            if (rcnt_ff == '0) begin
               state_in = S_IDLE;
            end else if (slot_free) begin
               fin          = (rd_ff + CW'(1) == rcnt_ff);
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff[rd_ff[IW-1:0]];
               rsp_last_in  = fin;
               rsp_done_in  = fin && last_ff;
               rd_in        = rd_ff + CW'(1);
               if (fin) begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_TEXT;
         pc_ff        <= '0;
         pstart_ff    <= '0;
         cp_ff        <= '0;
         rcnt_ff      <= '0;
         rd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         pc_ff        <= pc_in;
         pstart_ff    <= pstart_in;
         cp_ff        <= cp_in;
         rcnt_ff      <= rcnt_in;
         rd_ff        <= rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      qlen_ff     <= qlen_in;
      pos_ff      <= pos_in;
      s_ff        <= s_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
      for (int i = 0; i < MAX_DELIM; i++) begin
         q_ff[i]   <= q_in[i];
         res_ff[i] <= res_in[i];
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_done_ff;

`ifndef SYNTH
   // end of text is only ever flagged on the last byte of a run
   a_done_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("text_done without run_last");

   // the waiting buffer holds fewer than MAX_DELIM bytes between inputs
   a_pending_fits : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (int'(pc_ff) < MAX_DELIM))
      else $error("pending bytes overflow");

   // after the end-of-text flush all text state is back at reset
   a_flush_clears : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN && last_ff) |-> (pc_ff == '0 && mode_ff == MODE_TEXT))
      else $error("state not cleared at end of text");

   // results of one input never exceed the queue depth
   a_result_bound : assert property (@(posedge clock) disable iff (reset)
      int'(rcnt_ff) <= MAX_DELIM)
      else $error("result buffer overflow");
`endif

endmodule
